// ===== rtl/lcs_pkg.sv =====
// Package for the linear contrast stretch block.
// Holds the pixel width, the pixel type and the transaction kind codes; no dependencies.
package lcs_pkg;

	localparam int unsigned PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
	localparam logic [PIX_W-1:0] PIX_MIN = '0;

	// Kind of an input transaction, carried on s_tuser.
	localparam logic KIND_GATHER  = 1'b0;
	localparam logic KIND_STRETCH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== rtl/linear_contrast_stretch.sv =====
// Linear contrast stretch of 8-bit grey pixels, top level.
// Depends on lcs_pkg for the pixel type, its limits and the kind codes.
// Holds the statistics registers, the shift-subtract divider and its sequencer.

// Each frame is sent twice. On the first pass, gather transactions (tuser = 0) track the
// running minimum and maximum pixel. The gather transaction with tlast set commits that
// pair as the active range and resets the running pair. On the second pass, stretch
// transactions (tuser = 1) each return one pixel equal to
// floor((p - low) * 255 / (high - low)), giving 0 at or below the low end and 255 at or
// above the high end. While the active low equals the active high, the pixel passes
// through unchanged. Gather transactions return nothing.
// Sequence: a gather transaction is handled in its acceptance cycle, and the block is
// ready again on the next cycle. A stretch transaction that needs a real division goes
// from acceptance through a setup state, eight quotient steps of a single restoring
// divider (one compare and subtract per step) and a state that loads the output register.
// A stretch transaction at a range end, or with an empty range, skips the divider and
// goes through acceptance, setup and load only. s_tready is low while a stretch
// transaction is being worked on. The result sits in an output register. If that
// register is still held by m_tready, the sequencer waits before it loads the next
// result.
module linear_contrast_stretch
	import lcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] pixel
	input  logic         s_tuser,   // [0] kind: 0 gather, 1 stretch
	input  logic         s_tlast,   // last pixel of the frame
	// Output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // [7:0] pixel_out
	output logic         m_tlast    // last_out
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam int unsigned STEP_W = $clog2(PIX_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PIX_W - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;

	// Frame statistics.
	pix_t run_low_q;
	pix_t run_high_q;
	pix_t act_low_q;
	pix_t act_high_q;

	// Item being stretched, and the divider registers.
	pix_t pix_q;
	logic last_q;
	pix_t num_q;     // low numerator bits still to be shifted in
	pix_t rem_q;     // partial remainder, always below div_q during division
	pix_t div_q;     // active range
	pix_t quo_q;     // quotient, or the final result for the trivial cases

	// Output register.
	logic m_tvalid_q;
	pix_t m_tdata_q;
	logic m_tlast_q;

	logic in_fire;
	logic out_free;
	pix_t in_pix;
	pix_t gather_low;
	pix_t gather_high;
	pix_t diff;
	logic [2*PIX_W-1:0] numer;
	logic [PIX_W:0] trial;
	logic [PIX_W:0] trial_sub;
	logic trial_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign in_pix   = s_tdata[PIX_W-1:0];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Running minimum and maximum including the incoming gather pixel.
	assign gather_low  = (in_pix < run_low_q) ? in_pix : run_low_q;
	assign gather_high = (in_pix > run_high_q) ? in_pix : run_high_q;

	// Numerator (p - low) * 255, formed as a shift and a subtract.
	assign diff  = pix_q - act_low_q;
	assign numer = {diff, PIX_W'(0)} - {PIX_W'(0), diff};

	// The shared divider unit: one trial subtract per quotient bit.
	assign trial     = {rem_q, num_q[PIX_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign trial_ok  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			run_low_q  <= PIX_MAX;
			run_high_q <= PIX_MIN;
			act_low_q  <= PIX_MIN;
			act_high_q <= PIX_MIN;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result takes the register; otherwise an accepted one leaves it.
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == KIND_GATHER) begin
							if (s_tlast) begin
								act_low_q  <= gather_low;
								act_high_q <= gather_high;
								run_low_q  <= PIX_MAX;
								run_high_q <= PIX_MIN;
							end else begin
								run_low_q  <= gather_low;
								run_high_q <= gather_high;
							end
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					if ((act_low_q == act_high_q) || (pix_q <= act_low_q)
							|| (pix_q >= act_high_q)) begin
						state_q <= ST_OUT;
					end else begin
						step_q  <= STEP_LAST;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (s_tuser == KIND_STRETCH)) begin
					pix_q  <= in_pix;
					last_q <= s_tlast;
				end
			end
			ST_PREP: begin
				div_q <= act_high_q - act_low_q;
				rem_q <= numer[2*PIX_W-1:PIX_W];
				num_q <= numer[PIX_W-1:0];
				if (act_low_q == act_high_q) begin
					quo_q <= pix_q;
				end else if (pix_q <= act_low_q) begin
					quo_q <= PIX_MIN;
				end else if (pix_q >= act_high_q) begin
					quo_q <= PIX_MAX;
				end else begin
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= trial_ok ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
				num_q <= {num_q[PIX_W-2:0], 1'b0};
				quo_q <= {quo_q[PIX_W-2:0], trial_ok};
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= quo_q;
					m_tlast_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	// Every commit covers its own pixel, so the active pair never inverts.
	a_active_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		act_low_q <= act_high_q)
		else $error("active range inverted");

	// The partial remainder stays below the divisor on every quotient step.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("divider remainder out of range");

	// An accepted stretch transaction always enters the setup cycle.
	a_stretch_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_tuser == KIND_STRETCH)) |=> (state_q == ST_PREP))
		else $error("stretch transaction not started");

	// A result is loaded only when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && m_tvalid_q && !m_tready) |=> (state_q == ST_OUT))
		else $error("output register overwritten");
`endif

endmodule

// ===== sim/linear_contrast_stretch_tb.sv =====
// Self-checking testbench for the linear contrast stretch block.
// Depends on lcs_pkg and rtl/linear_contrast_stretch.sv; holds its own pixel predictor.
`timescale 1ns / 1ps

module linear_contrast_stretch_tb
	import lcs_pkg::*;
;

	// Pixel distributions for generated frames.
	localparam int STYLE_WIDE   = 0;
	localparam int STYLE_NARROW = 1;
	localparam int STYLE_FLAT   = 2;
	localparam int STYLE_ENDS   = 3;

	localparam int ITEM_TARGET = 2000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} stretched_t;

	// Tracks the min/max statistics the same way the block should and queues the
	// stretched pixel expected for every stretch transaction.
	class contrast_scoreboard;
		pix_t       run_lo, run_hi, act_lo, act_hi;
		stretched_t pending[$];
		int         errors;

		function new();
			run_lo = PIX_MAX;
			run_hi = PIX_MIN;
			act_lo = PIX_MIN;
			act_hi = PIX_MIN;
			errors = 0;
		endfunction

		function pix_t stretch_of(pix_t p);
			int unsigned span, diff, q;
			if (act_lo == act_hi) return p;
			span = pix_t'(act_hi - act_lo);
			if (span == 0) return p;
			if (p <= act_lo) return PIX_MIN;
			diff = p - act_lo;
			q = diff * PIX_MAX / span;
			return (q > PIX_MAX) ? PIX_MAX : pix_t'(q);
		endfunction

		function void note_input(logic kind, pix_t p, logic l);
			stretched_t e;
			if (kind == KIND_GATHER) begin
				if (p < run_lo) run_lo = p;
				if (p > run_hi) run_hi = p;
				if (l) begin
					act_lo = run_lo;
					act_hi = run_hi;
					run_lo = PIX_MAX;
					run_hi = PIX_MIN;
				end
			end else begin
				e.pixel = stretch_of(p);
				e.last  = l;
				pending.push_back(e);
			end
		endfunction

		function void check_output(pix_t p, logic l);
			stretched_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result pixel=%0d last=%0b", $time, p, l);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (p !== e.pixel) begin
				$display("%0t: pixel mismatch, expected %0d, actual %0d", $time, e.pixel, p);
				errors++;
			end
			if (l !== e.last) begin
				$display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = KIND_GATHER;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;

	contrast_scoreboard sb;
	bit steady = 1'b0;        // no idling on either side while set
	bit hold_request = 1'b0;  // asks the receiver for one long hold-off
	int items_sent = 0;

	linear_contrast_stretch dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Monitors sample both streams at the rising edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tuser, s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_output(m_tdata, m_tlast);
	end

	// Receiver: random stalls, plus one counted hold-off whenever it is asked for.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	// Offers one transaction, starting at a falling edge, and returns at the falling
	// edge after it was accepted.
	task automatic send_item(input logic kind, input pix_t p, input logic l);
		while (!steady && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= p;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic pix_t pick_pixel(int style, pix_t base, int spread);
		int v;
		case (style)
			STYLE_WIDE: v = $urandom_range(0, 255);
			STYLE_NARROW: v = base + $urandom_range(0, spread);
			STYLE_FLAT: v = base;
			default: begin
				case ($urandom_range(0, 3))
					0: v = PIX_MIN;
					1: v = PIX_MAX;
					default: v = $urandom_range(0, 255);
				endcase
			end
		endcase
		return (v > PIX_MAX) ? PIX_MAX : pix_t'(v);
	endfunction

	// Gather pass over a frame, then a stretch pass over the same frame with a few
	// pixels swapped for arbitrary values so that both range ends get overshot.
	task automatic send_frame();
		pix_t frame[$];
		int len, style, spread;
		pix_t base;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
		style = $urandom_range(STYLE_WIDE, STYLE_ENDS);
		base = pix_t'($urandom_range(0, 255));
		spread = $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			frame.push_back(pick_pixel(style, base, spread));
		for (int i = 0; i < len; i++)
			send_item(KIND_GATHER, frame[i], i == len - 1);
		for (int i = 0; i < len; i++)
			send_item(KIND_STRETCH,
				($urandom_range(0, 4) == 0) ? pix_t'($urandom_range(0, 255)) : frame[i],
				i == len - 1);
	endtask

	initial begin
		int pick;
		int frames;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty range straight after reset: pixels pass through.
		send_item(KIND_STRETCH, 8'd0, 1'b0);
		send_item(KIND_STRETCH, 8'd255, 1'b1);
		// A one-pixel frame leaves low equal to high.
		send_item(KIND_GATHER, 8'd77, 1'b1);
		send_item(KIND_STRETCH, 8'd13, 1'b0);
		// Range 10..200, probed below, at and above both ends.
		send_item(KIND_GATHER, 8'd200, 1'b0);
		send_item(KIND_GATHER, 8'd10, 1'b0);
		send_item(KIND_GATHER, 8'd150, 1'b1);
		send_item(KIND_STRETCH, 8'd0, 1'b0);
		send_item(KIND_STRETCH, 8'd10, 1'b0);
		send_item(KIND_STRETCH, 8'd11, 1'b0);
		send_item(KIND_STRETCH, 8'd105, 1'b0);
		send_item(KIND_STRETCH, 8'd199, 1'b0);
		send_item(KIND_STRETCH, 8'd200, 1'b0);
		send_item(KIND_STRETCH, 8'd255, 1'b1);
		// Full range.
		send_item(KIND_GATHER, PIX_MAX, 1'b0);
		send_item(KIND_GATHER, PIX_MIN, 1'b1);
		send_item(KIND_STRETCH, 8'd0, 1'b0);
		send_item(KIND_STRETCH, 8'd128, 1'b0);
		send_item(KIND_STRETCH, 8'd254, 1'b0);
		send_item(KIND_STRETCH, 8'd255, 1'b1);
		// Range collapsed at zero.
		send_item(KIND_GATHER, PIX_MIN, 1'b1);
		send_item(KIND_STRETCH, 8'd255, 1'b1);

		frames = 0;
		while (items_sent < ITEM_TARGET) begin
			if (frames == 3 || frames == 60)
				hold_request = 1'b1;
			steady = (items_sent > 800 && items_sent < 1100);
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				send_frame();
			end else if (pick <= 8) begin
				// Noise: arbitrary kind, pixel and last flag.
				repeat ($urandom_range(1, 8))
					send_item(1'($urandom_range(0, 1)), pix_t'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end else begin
				// Broken frame: gather without a closing last, then stretch on the old range.
				repeat ($urandom_range(1, 6))
					send_item(KIND_GATHER, pix_t'($urandom_range(0, 255)), 1'b0);
				repeat ($urandom_range(1, 6))
					send_item(KIND_STRETCH, pix_t'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end
			frames++;
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.pending.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lcs_pkg.sv
rtl/linear_contrast_stretch.sv
sim/linear_contrast_stretch_tb.sv
